// File: hdl/fes_pkg.sv
`timescale 1ns / 1ps

package fes_pkg;

    typedef logic [2:0] cmd_t;
    typedef logic [1:0] phase_t;
    typedef logic [7:0] alpha_t;
    typedef logic [1:0] cfg_index_t;

    localparam cmd_t CMD_TICK     = 3'd0;
    localparam cmd_t CMD_SHOW     = 3'd1;
    localparam cmd_t CMD_FADE_IN  = 3'd2;
    localparam cmd_t CMD_FADE_OUT = 3'd3;
    localparam cmd_t CMD_RESTART  = 3'd4;

    localparam phase_t PH_UP   = 2'd0;
    localparam phase_t PH_HOLD = 2'd1;
    localparam phase_t PH_DOWN = 2'd2;
    localparam phase_t PH_DONE = 2'd3;

    localparam cfg_index_t CFG_FADE_IN  = 2'd0;
    localparam cfg_index_t CFG_HOLD     = 2'd1;
    localparam cfg_index_t CFG_FADE_OUT = 2'd2;

    localparam int     REG_WIDTH = 32;
    localparam alpha_t ALPHA_MAX = 8'd255;
    localparam alpha_t ALPHA_MIN = 8'd0;
    localparam int     DIV_STEPS = 8;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EVAL  = 4'b0010,
        S_DIV   = 4'b0100,
        S_WRITE = 4'b1000
    } state_t;

endpackage

// File: hdl/fade_envelope_sequencer.sv
`timescale 1ns / 1ps
// Flow: an accepted word is registered, then S_EVAL applies the command and forms elapsed*255;
// a tick inside a ramp then runs the eight steps of the shared restoring divider in S_DIV.
// Every result then waits in S_WRITE until the output register is free of out_stall.
// A new word is taken only while the sequencer idles.
// Reset: rst_n clears phase, alpha, running, phase start and the three duration registers.
module fade_envelope_sequencer #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  fes_pkg::cmd_t        command,
    input  logic [31:0]          now,
    output logic                 out_valid,
    input  logic                 out_stall,
    output fes_pkg::alpha_t      alpha,
    output fes_pkg::phase_t      phase,
    output logic                 running,
    input  logic                 cfg_wr_en,
    input  fes_pkg::cfg_index_t  cfg_index,
    input  logic [31:0]          cfg_wdata
);

    import fes_pkg::*;

    localparam int CW = (TIME_WIDTH > REG_WIDTH) ? TIME_WIDTH : REG_WIDTH;
    localparam int PW = REG_WIDTH + 8;

    state_t                  state_reg, state_next;
    logic [REG_WIDTH-1:0]    fade_in_reg, fade_in_next;
    logic [REG_WIDTH-1:0]    hold_reg, hold_next;
    logic [REG_WIDTH-1:0]    fade_out_reg, fade_out_next;
    phase_t                  phase_reg, phase_next;
    logic                    running_reg, running_next;
    logic [TIME_WIDTH-1:0]   phase_start_reg, phase_start_next;
    alpha_t                  alpha_reg, alpha_next;
    logic                    out_valid_reg, out_valid_next;
    alpha_t                  out_alpha_reg, out_alpha_next;
    phase_t                  out_phase_reg, out_phase_next;
    logic                    out_running_reg, out_running_next;

    cmd_t                    cmd_reg, cmd_next;
    logic [TIME_WIDTH-1:0]   now_reg, now_next;
    logic [CW-1:0]           elapsed_reg, elapsed_next;
    logic [REG_WIDTH-1:0]    rem_reg, rem_next;
    logic [7:0]              lo_reg, lo_next;
    logic [7:0]              quo_reg, quo_next;
    logic [2:0]              cnt_reg, cnt_next;
    logic [REG_WIDTH-1:0]    dur_reg, dur_next;
    logic                    down_reg, down_next;

    logic                    accept;
    logic                    out_free;
    logic [CW-1:0]           now_ext;
    logic [TIME_WIDTH-1:0]   now_tw;
    logic [TIME_WIDTH-1:0]   elapsed_tw;
    logic [REG_WIDTH-1:0]    ramp_dur;
    logic                    ramp_done;
    logic                    hold_done;
    logic [REG_WIDTH-1:0]    e32;
    logic [PW-1:0]           prod;
    logic [REG_WIDTH:0]      trial;
    logic                    trial_ge;
    logic [7:0]              quo_shift;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign alpha     = out_alpha_reg;
    assign phase     = out_phase_reg;
    assign running   = out_running_reg;

    assign now_ext    = CW'(now);
    assign now_tw     = now_ext[TIME_WIDTH-1:0];
    assign elapsed_tw = now_tw - phase_start_reg;

    assign ramp_dur  = (phase_reg == PH_UP) ? fade_in_reg : fade_out_reg;
    assign ramp_done = (elapsed_reg >= CW'(ramp_dur));
    assign hold_done = (elapsed_reg >= CW'(hold_reg));
    assign e32       = elapsed_reg[REG_WIDTH-1:0];
    assign prod      = {e32, 8'd0} - PW'(e32);

    assign trial     = {rem_reg, lo_reg[7]};
    assign trial_ge  = (trial >= {1'b0, dur_reg});
    assign quo_shift = {quo_reg[6:0], trial_ge};

    always_comb
    begin
        state_next       = state_reg;
        fade_in_next     = fade_in_reg;
        hold_next        = hold_reg;
        fade_out_next    = fade_out_reg;
        phase_next       = phase_reg;
        running_next     = running_reg;
        phase_start_next = phase_start_reg;
        alpha_next       = alpha_reg;
        out_valid_next   = out_valid_reg;
        out_alpha_next   = out_alpha_reg;
        out_phase_next   = out_phase_reg;
        out_running_next = out_running_reg;
        cmd_next         = cmd_reg;
        now_next         = now_reg;
        elapsed_next     = elapsed_reg;
        rem_next         = rem_reg;
        lo_next          = lo_reg;
        quo_next         = quo_reg;
        cnt_next         = cnt_reg;
        dur_next         = dur_reg;
        down_next        = down_reg;

        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_FADE_IN:  fade_in_next  = cfg_wdata;
                CFG_HOLD:     hold_next     = cfg_wdata;
                CFG_FADE_OUT: fade_out_next = cfg_wdata;
                default:      ;
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next     = command;
                    now_next     = now_tw;
                    elapsed_next = CW'(elapsed_tw);
                    state_next   = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_WRITE;
                rem_next   = prod[PW-1:8];
                lo_next    = prod[7:0];
                quo_next   = 8'd0;
                cnt_next   = 3'd0;
                dur_next   = ramp_dur;
                down_next  = (phase_reg == PH_DOWN);
                unique case (cmd_reg)
                    CMD_TICK:
                    begin
                        unique case (phase_reg)
                            PH_UP:
                            begin
                                if (running_reg)
                                begin
                                    if (ramp_done)
                                    begin
                                        alpha_next       = ALPHA_MAX;
                                        phase_next       = PH_HOLD;
                                        phase_start_next = now_reg;
                                    end
                                    else
                                    begin
                                        state_next = S_DIV;
                                    end
                                end
                            end
                            PH_HOLD:
                            begin
                                if (hold_done)
                                begin
                                    phase_next       = PH_DOWN;
                                    phase_start_next = now_reg;
                                end
                            end
                            PH_DOWN:
                            begin
                                if (ramp_done)
                                begin
                                    alpha_next   = ALPHA_MIN;
                                    phase_next   = PH_DONE;
                                    running_next = 1'b0;
                                end
                                else
                                begin
                                    state_next = S_DIV;
                                end
                            end
                            default: ;
                        endcase
                    end
                    CMD_SHOW:
                    begin
                        if (!running_reg)
                        begin
                            running_next     = 1'b1;
                            phase_start_next = now_reg;
                        end
                    end
                    CMD_FADE_IN:
                    begin
                        running_next     = 1'b1;
                        phase_start_next = now_reg;
                        alpha_next       = ALPHA_MIN;
                        phase_next       = PH_UP;
                    end
                    CMD_FADE_OUT:
                    begin
                        alpha_next       = ALPHA_MAX;
                        phase_start_next = now_reg;
                        phase_next       = PH_DOWN;
                    end
                    CMD_RESTART:
                    begin
                        running_next = 1'b0;
                        alpha_next   = ALPHA_MIN;
                        phase_next   = PH_UP;
                    end
                    default: ;
                endcase
            end
            S_DIV:
            begin
                rem_next = trial_ge ? REG_WIDTH'(trial - {1'b0, dur_reg})
                                    : trial[REG_WIDTH-1:0];
                lo_next  = {lo_reg[6:0], 1'b0};
                quo_next = quo_shift;
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'(DIV_STEPS - 1))
                begin
                    alpha_next = down_reg ? (ALPHA_MAX - quo_shift) : quo_shift;
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_alpha_next   = alpha_reg;
                    out_phase_next   = phase_reg;
                    out_running_next = running_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            fade_in_reg     <= '0;
            hold_reg        <= '0;
            fade_out_reg    <= '0;
            phase_reg       <= PH_UP;
            running_reg     <= 1'b0;
            phase_start_reg <= '0;
            alpha_reg       <= ALPHA_MIN;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            fade_in_reg     <= fade_in_next;
            hold_reg        <= hold_next;
            fade_out_reg    <= fade_out_next;
            phase_reg       <= phase_next;
            running_reg     <= running_next;
            phase_start_reg <= phase_start_next;
            alpha_reg       <= alpha_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_alpha_reg   <= out_alpha_next;
        out_phase_reg   <= out_phase_next;
        out_running_reg <= out_running_next;
        cmd_reg         <= cmd_next;
        now_reg         <= now_next;
        elapsed_reg     <= elapsed_next;
        rem_reg         <= rem_next;
        lo_reg          <= lo_next;
        quo_reg         <= quo_next;
        cnt_reg         <= cnt_next;
        dur_reg         <= dur_next;
        down_reg        <= down_next;
    end

endmodule
